/* rtl/mtvo_pkg.sv */
`timescale 1ns / 1ps
package mtvo_pkg;

   localparam int MAX_TONES_DEF    = 8;
   localparam int CORDIC_STEPS_DEF = 16;

   localparam int REQ_DATA_W = 136;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 96;
   localparam int RSP_USER_W = 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam int CORDIC_W = 34;
   localparam int TERM_W   = 33;

   localparam logic [CORDIC_W-1:0] CORDIC_GAIN_Q30 = 34'd652032874;
   localparam logic [47:0] END_TIME_RESET = 48'd6553600000000;

   localparam logic ACT_EVAL = 1'b0;
   localparam logic ACT_LOAD = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_REF_X      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_Y      = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REF_Z      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_END_TIME   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_TONE_COUNT = 3'd5;

   localparam logic [1:0] COMP_X    = 2'd0;
   localparam logic [1:0] COMP_Y    = 2'd1;
   localparam logic [1:0] COMP_Z    = 2'd2;
   localparam logic [1:0] COMP_NONE = 2'd3;

   typedef enum logic [1:0] {
      CS_IDLE,
      CS_RUN,
      CS_ROUND
   } cordic_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_TURN,
      ST_START,
      ST_SINE,
      ST_AMP,
      ST_ACC,
      ST_DONE
   } seq_state_type;

   // arctangent of 2^-i in 2^-32 turn units, truncated
   function automatic logic [31:0] atan_turn(input logic [4:0] i);
      logic [31:0] r;
      case (i)
         5'd0:  r = 32'h20000000;
         5'd1:  r = 32'h12E4051D;
         5'd2:  r = 32'h09FB385B;
         5'd3:  r = 32'h051111D4;
         5'd4:  r = 32'h028B0D43;
         5'd5:  r = 32'h0145D7E1;
         5'd6:  r = 32'h00A2F61E;
         5'd7:  r = 32'h00517C55;
         5'd8:  r = 32'h0028BE53;
         5'd9:  r = 32'h00145F2E;
         5'd10: r = 32'h000A2F98;
         5'd11: r = 32'h000517CC;
         5'd12: r = 32'h00028BE6;
         5'd13: r = 32'h000145F3;
         5'd14: r = 32'h0000A2F9;
         5'd15: r = 32'h0000517C;
         5'd16: r = 32'h000028BE;
         5'd17: r = 32'h0000145F;
         5'd18: r = 32'h00000A2F;
         5'd19: r = 32'h00000517;
         5'd20: r = 32'h0000028B;
         5'd21: r = 32'h00000145;
         5'd22: r = 32'h000000A2;
         5'd23: r = 32'h00000051;
         default: r = 32'h00000000;
      endcase
      return r;
   endfunction

endpackage

/* rtl/multi_tone_vector_offset_top.sv */
`timescale 1ns / 1ps
// a load transaction is taken and gives no result; an evaluate transaction steps
// through READ, TURN, START, SINE, AMP and ACC for each of n summed tones, then DONE
// loads the output register; it goes straight to DONE when none are summed
// requests are taken only in IDLE, so one evaluate runs at a time through the
// shared cordic rotator, and DONE waits while a previous result is held
// reset: synchronous, active high; clears control and configuration registers,
// the tone table is not cleared and holds garbage until loaded
module multi_tone_vector_offset_top #(
   parameter int MAX_TONES    = mtvo_pkg::MAX_TONES_DEF,
   parameter int CORDIC_STEPS = mtvo_pkg::CORDIC_STEPS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // time_now[47:0] tone_index[50:48] tone_amplitude[82:51]
   // tone_frequency[114:83] tone_phase[130:115], zero pad to 136
   input  logic [mtvo_pkg::REQ_DATA_W-1:0]    req_tdata,
   // action[0]
   input  logic [mtvo_pkg::REQ_USER_W-1:0]    req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // out_x[31:0] out_y[63:32] out_z[95:64]
   output logic [mtvo_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // oscillating[0]
   output logic [mtvo_pkg::RSP_USER_W-1:0]    rsp_tuser,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [mtvo_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [mtvo_pkg::CSR_DATA_W-1:0]    csr_data
);
   import mtvo_pkg::*;

   localparam int IDXW = (MAX_TONES > 1) ? $clog2(MAX_TONES) : 1;
   localparam int CNTW = $clog2(MAX_TONES + 1);
   localparam int SUMW = TERM_W + $clog2(MAX_TONES) + 1;
   localparam int VECW = SUMW + 1;

   // request fields
   logic        action;
   logic [47:0] time_now;
   logic [2:0]  tone_index;
   logic [31:0] tone_amplitude;
   logic [31:0] tone_frequency;
   logic [15:0] tone_phase;

   assign action         = req_tuser[0];
   assign time_now       = req_tdata[47:0];
   assign tone_index     = req_tdata[50:48];
   assign tone_amplitude = req_tdata[82:51];
   assign tone_frequency = req_tdata[114:83];
   assign tone_phase     = req_tdata[130:115];

   // configuration registers
   logic [31:0] ref_x_ff, ref_y_ff, ref_z_ff;
   logic [1:0]  target_ff;
   logic [47:0] end_time_ff;
   logic [3:0]  tone_count_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff      <= '0;
         ref_y_ff      <= '0;
         ref_z_ff      <= '0;
         target_ff     <= COMP_X;
         end_time_ff   <= END_TIME_RESET;
         tone_count_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_REF_X:      ref_x_ff      <= csr_data[31:0];
            CSR_REF_Y:      ref_y_ff      <= csr_data[31:0];
            CSR_REF_Z:      ref_z_ff      <= csr_data[31:0];
            CSR_TARGET:     target_ff     <= csr_data[1:0];
            CSR_END_TIME:   end_time_ff   <= csr_data[47:0];
            CSR_TONE_COUNT: tone_count_ff <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   // sequencer
   seq_state_type state_ff, state_in;

   logic            req_accept;
   logic            rsp_free;
   logic            mem_we;
   logic [CNTW-1:0] n_eff;
   logic            active;
   logic            last_tone;

   logic [31:0]     t_lo_ff;
   logic [CNTW-1:0] n_ff;
   logic [IDXW-1:0] idx_ff;
   logic            osc_ff;
   logic [31:0]     turn_ff;
   logic signed [47:0]     prod_ff;
   logic signed [SUMW-1:0] sum_ff;

   logic [31:0] rd_amp, rd_freq;
   logic [15:0] rd_phase;
   logic        cordic_start;
   logic        cordic_done;
   logic [15:0] cordic_sine;
   logic [31:0] cordic_angle;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_free   = !rsp_tvalid || rsp_tready;

   // loads beyond the table are dropped
   assign mem_we = req_accept && (action == ACT_LOAD) && (32'(tone_index) < 32'(MAX_TONES));

   always_comb begin
      if (32'(tone_count_ff) > 32'(MAX_TONES))
         n_eff = CNTW'(MAX_TONES);
      else
         n_eff = CNTW'(tone_count_ff);
   end

   assign active    = (time_now < end_time_ff) && (target_ff != COMP_NONE) && (n_eff != '0);
   assign last_tone = ((CNTW'(idx_ff) + CNTW'(1)) == n_ff);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:
            if (req_accept && action == ACT_EVAL)
               state_in = active ? ST_READ : ST_DONE;
         ST_READ:  state_in = ST_TURN;
         ST_TURN:  state_in = ST_START;
         ST_START: state_in = ST_SINE;
         ST_SINE:  if (cordic_done) state_in = ST_AMP;
         ST_AMP:   state_in = ST_ACC;
         ST_ACC:   state_in = last_tone ? ST_DONE : ST_READ;
         ST_DONE:  if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   mtvo_tone_mem #(
      .DEPTH (MAX_TONES),
      .IDXW  (IDXW)
   ) u_tone_mem (
      .clock    (clock),
      .wr_en    (mem_we),
      .wr_addr  (IDXW'(tone_index)),
      .wr_amp   (tone_amplitude),
      .wr_freq  (tone_frequency),
      .wr_phase (tone_phase),
      .rd_addr  (idx_ff),
      .rd_amp   (rd_amp),
      .rd_freq  (rd_freq),
      .rd_phase (rd_phase)
   );

   // angle in turns: frequency times time, whole turns dropped, plus phase
   assign cordic_start = (state_ff == ST_START);
   assign cordic_angle = turn_ff + {rd_phase, 16'h0000};

   mtvo_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .start (cordic_start),
      .angle (cordic_angle),
      .done  (cordic_done),
      .sine  (cordic_sine)
   );

   logic signed [47:0]     prod_rnd;
   logic signed [TERM_W-1:0] term;

   assign prod_rnd = prod_ff + 48'sd16384;
   assign term     = prod_rnd[47:15];

   always_ff @(posedge clock) begin
      if (req_accept && action == ACT_EVAL) begin
         t_lo_ff <= time_now[31:0];
         n_ff    <= n_eff;
         idx_ff  <= '0;
         sum_ff  <= '0;
         osc_ff  <= active;
      end
      if (state_ff == ST_TURN)
         turn_ff <= 32'(rd_freq * t_lo_ff);
      if (state_ff == ST_AMP)
         prod_ff <= $signed(rd_amp) * $signed(cordic_sine);
      if (state_ff == ST_ACC) begin
         sum_ff <= sum_ff + {{(SUMW - TERM_W){term[TERM_W-1]}}, term};
         if (!last_tone) idx_ff <= idx_ff + IDXW'(1);
      end
   end

   // final vector: one adder on the selected component, then saturation
   logic [31:0]            base;
   logic signed [VECW-1:0] total;
   logic [31:0]            total_sat;

   always_comb begin
      case (target_ff)
         COMP_X:  base = ref_x_ff;
         COMP_Y:  base = ref_y_ff;
         COMP_Z:  base = ref_z_ff;
         default: base = ref_x_ff;
      endcase
      total = VECW'(signed'(base)) + VECW'(sum_ff);
      if (total[VECW-1:31] == '0 || total[VECW-1:31] == '1)
         total_sat = total[31:0];
      else if (total[VECW-1])
         total_sat = 32'h80000000;
      else
         total_sat = 32'h7FFFFFFF;
   end

   // output register, loaded in DONE once the previous result is taken or none is held
   logic        rsp_valid_ff;
   logic [95:0] rsp_data_ff;
   logic        rsp_osc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_data_ff[31:0]  <= (osc_ff && target_ff == COMP_X) ? total_sat : ref_x_ff;
         rsp_data_ff[63:32] <= (osc_ff && target_ff == COMP_Y) ? total_sat : ref_y_ff;
         rsp_data_ff[95:64] <= (osc_ff && target_ff == COMP_Z) ? total_sat : ref_z_ff;
         rsp_osc_ff         <= osc_ff;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_osc_ff;

endmodule

/* rtl/mtvo_tone_mem.sv */
`timescale 1ns / 1ps
module mtvo_tone_mem #(
   parameter int DEPTH = mtvo_pkg::MAX_TONES_DEF,
   parameter int IDXW  = 3
) (
   input  logic            clock,
   input  logic            wr_en,
   input  logic [IDXW-1:0] wr_addr,
   input  logic [31:0]     wr_amp,
   input  logic [31:0]     wr_freq,
   input  logic [15:0]     wr_phase,
   input  logic [IDXW-1:0] rd_addr,
   output logic [31:0]     rd_amp,
   output logic [31:0]     rd_freq,
   output logic [15:0]     rd_phase
);
   import mtvo_pkg::*;

   logic [31:0] amp_mem   [DEPTH];
   logic [31:0] freq_mem  [DEPTH];
   logic [15:0] phase_mem [DEPTH];

   logic [31:0] rd_amp_ff;
   logic [31:0] rd_freq_ff;
   logic [15:0] rd_phase_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         amp_mem[wr_addr]   <= wr_amp;
         freq_mem[wr_addr]  <= wr_freq;
         phase_mem[wr_addr] <= wr_phase;
      end
   end

   always_ff @(posedge clock) begin
      rd_amp_ff   <= amp_mem[rd_addr];
      rd_freq_ff  <= freq_mem[rd_addr];
      rd_phase_ff <= phase_mem[rd_addr];
   end

   assign rd_amp   = rd_amp_ff;
   assign rd_freq  = rd_freq_ff;
   assign rd_phase = rd_phase_ff;

endmodule

/* rtl/mtvo_cordic.sv */
`timescale 1ns / 1ps
module mtvo_cordic #(
   parameter int CORDIC_STEPS = mtvo_pkg::CORDIC_STEPS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [31:0] angle,
   output logic        done,
   output logic [15:0] sine
);
   import mtvo_pkg::*;

   localparam int SW = $clog2(CORDIC_STEPS);

   cordic_state_type state_ff, state_in;

   logic signed [CORDIC_W-1:0] x_ff, y_ff, z_ff;
   logic [SW-1:0]              step_ff;
   logic                       flip_ff;
   logic                       done_ff;
   logic [15:0]                sine_ff;

   logic                       flip;
   logic [31:0]                folded;
   logic signed [CORDIC_W-1:0] x_sh, y_sh, at, y_fin, y_rnd, q;
   logic                       last_step;

   // fold the left half-plane onto the right one, negate at the end
   assign flip   = angle[31] ^ angle[30];
   assign folded = {angle[31] ^ flip, angle[30:0]};

   assign x_sh      = x_ff >>> step_ff;
   assign y_sh      = y_ff >>> step_ff;
   assign at        = CORDIC_W'(atan_turn(5'(step_ff)));
   assign last_step = (step_ff == SW'(CORDIC_STEPS - 1));

   assign y_fin = flip_ff ? -y_ff : y_ff;
   assign y_rnd = y_fin + CORDIC_W'(16384);
   assign q     = y_rnd >>> 15;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         CS_IDLE:  if (start) state_in = CS_RUN;
         CS_RUN:   if (last_step) state_in = CS_ROUND;
         CS_ROUND: state_in = CS_IDLE;
         default:  state_in = CS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == CS_ROUND);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               x_ff    <= CORDIC_GAIN_Q30;
               y_ff    <= '0;
               z_ff    <= CORDIC_W'(signed'(folded));
               flip_ff <= flip;
               step_ff <= '0;
            end
         end
         CS_RUN: begin
            if (!z_ff[CORDIC_W-1]) begin
               x_ff <= x_ff - y_sh;
               y_ff <= y_ff + x_sh;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + y_sh;
               y_ff <= y_ff - x_sh;
               z_ff <= z_ff + at;
            end
            step_ff <= step_ff + SW'(1);
         end
         CS_ROUND: begin
            // saturate to q1.15
            if (q[CORDIC_W-1:15] == '0 || q[CORDIC_W-1:15] == '1)
               sine_ff <= q[15:0];
            else if (q[CORDIC_W-1])
               sine_ff <= 16'h8000;
            else
               sine_ff <= 16'h7FFF;
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign sine = sine_ff;

endmodule
